[src/itss_pkg.sv]
// Shared types and constants for the interval timer with smoothed statistics.
// Used by every module of the block; depends on nothing.

package itss_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TOTAL_W    = 48;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SMOOTH_W   = TIME_W + FRAC_W;
  localparam int unsigned SF_W       = 16;
  localparam int unsigned RATE_FRAC  = 24;
  localparam int unsigned RATE_W     = RATE_FRAC + 1;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned OUT_FIELDS_W = STATUS_W + 1 + 1 + COUNT_W + 2 * TIME_W
                                         + SMOOTH_W + 3 * RATE_W;
  localparam int unsigned OUT_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned DIV_NUM_W  = 64;
  localparam int unsigned DIV_DEN_W  = TOTAL_W;
  localparam int unsigned DIV_Q_W    = TIME_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_Q_W + 1);

  localparam logic [SF_W-1:0] SF_RESET = SF_W'(58982);

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_RUNNING     = 2'd1,
    ST_NOT_STARTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_e;

  typedef struct packed {
    act_e              act;
    status_e           status;
    logic              running;
    logic [TIME_W-1:0] dt;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic                 wide;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] q;
  } div_rsp_t;

endpackage

[src/interval_timer_with_smoothed_stats.sv]
// Top level of the interval timer with smoothed statistics.
// Depends on itss_pkg, itss_front, itss_fifo, itss_back (with itss_div).

// Every request (start, stop, clear, read) returns exactly one result. The front end
// takes a request per cycle into a two-entry queue as long as the queue has room. The
// back end works on one request at a time: a result that reports no statistics (timer
// running or no interval recorded) passes from the pop through S_PREP to S_DONE; a
// result with statistics first runs the shared restoring divider, which produces
// one quotient bit per clock, 32 bits for the mean and 25 bits for each of the three
// rates. A result still waiting in the output register holds the next one back. The
// smoothing factor may be written only while no request is pending.

module interval_timer_with_smoothed_stats import itss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SF_W-1:0]   cfg_data_i,     // smoothing_factor
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TIME_W-1:0] s_axis_tdata,   // timestamp
  input  logic [OP_W-1:0]   s_axis_tuser,   // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata    // status, running, ready_res, interval_count,
                                            // last_elapsed, mean_elapsed, smooth_elapsed,
                                            // last_rate, mean_rate, smooth_rate, zero pad
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t front_cmd;
  cmd_t back_cmd;

  itss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .full_i        (full)
  );

  itss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (back_cmd)
  );

  itss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (empty),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

[src/itss_front.sv]
// Front end: accepts requests, tracks the start/stop state and measures intervals.
// Depends on itss_pkg; feeds commands into itss_fifo.

module itss_front import itss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TIME_W-1:0] s_axis_tdata,   // timestamp
  input  logic [OP_W-1:0]   s_axis_tuser,   // op
  output logic              push_o,
  output cmd_t              cmd_o,
  input  logic              full_i
);

  logic              timing_q, timing_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [TIME_W-1:0] diff;
  op_e               op;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign op            = op_e'(s_axis_tuser);
  assign diff          = s_axis_tdata - stamp_q;

  always_comb begin
    timing_d      = timing_q;
    stamp_d       = stamp_q;
    cmd_o.act     = ACT_NONE;
    cmd_o.status  = ST_OK;
    cmd_o.dt      = (diff == '0) ? TIME_W'(1) : diff;
    case (op)
      OP_START: begin
        if (timing_q) begin
          cmd_o.status = ST_RUNNING;
        end else begin
          stamp_d  = s_axis_tdata;
          timing_d = 1'b1;
        end
      end
      OP_STOP: begin
        if (!timing_q) begin
          cmd_o.status = ST_NOT_STARTED;
        end else begin
          timing_d  = 1'b0;
          cmd_o.act = ACT_STOP;
        end
      end
      OP_CLEAR: begin
        timing_d  = 1'b0;
        stamp_d   = s_axis_tdata;
        cmd_o.act = ACT_CLEAR;
      end
      default: begin
      end
    endcase
    cmd_o.running = timing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q <= 1'b0;
      stamp_q  <= '0;
    end else if (push_o) begin
      timing_q <= timing_d;
      stamp_q  <= stamp_d;
    end
  end

endmodule

[src/itss_fifo.sv]
// Two-entry command queue between the front end and the back end.
// Depends on itss_pkg for the command type.

module itss_fifo import itss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[src/itss_div.sv]
// Shared restoring divider, one quotient bit per cycle, with saturation.
// Depends on itss_pkg; used by itss_back for the mean and the three rates.

module itss_div import itss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [DIV_Q_W-1:0] RATE_MAX_Q = DIV_Q_W'(1) << RATE_FRAC;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 wide_q, wide_d;
  logic                 zero_q, zero_d;
  logic                 sat_q, sat_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_Q_W-1:0]   lo_q, lo_d;
  logic [DIV_Q_W-1:0]   q_q, q_d;
  logic [DIV_NUM_W-1:0] hi;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   trial_sub;
  logic                 ge;

  assign hi        = req_i.wide ? (req_i.num >> DIV_Q_W) : (req_i.num >> RATE_W);
  assign trial     = {rem_q, lo_q[DIV_Q_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    wide_d = wide_q;
    zero_d = zero_q;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    q_d    = q_q;
    if (req_i.start) begin
      wide_d = req_i.wide;
      den_d  = req_i.den;
      zero_d = (req_i.den == '0);
      sat_d  = (hi >= DIV_NUM_W'(req_i.den));
      rem_d  = hi[DIV_DEN_W-1:0];
      lo_d   = req_i.wide ? req_i.num[DIV_Q_W-1:0]
                          : {req_i.num[RATE_W-1:0], {(DIV_Q_W-RATE_W){1'b0}}};
      q_d    = '0;
      cnt_d  = req_i.wide ? DIV_CNT_W'(DIV_Q_W) : DIV_CNT_W'(RATE_W);
      if (zero_d || sat_d) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      q_d   = {q_q[DIV_Q_W-2:0], ge};
      lo_d  = lo_q << 1;
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    if (zero_q) begin
      rsp_o.q = '0;
    end else if (sat_q) begin
      rsp_o.q = wide_q ? '1 : RATE_MAX_Q;
    end else if (!wide_q && (q_q > RATE_MAX_Q)) begin
      rsp_o.q = RATE_MAX_Q;
    end else begin
      rsp_o.q = q_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      wide_q <= 1'b0;
      zero_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      wide_q <= wide_d;
      zero_q <= zero_d;
      sat_q  <= sat_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
    q_q   <= q_d;
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !req_i.start)
    else $error("divider restarted while busy");
`endif

endmodule

[src/itss_back.sv]
// Back end: updates the statistics, runs the divisions and holds the result register.
// Depends on itss_pkg and itss_div; pops commands from itss_fifo.

module itss_back import itss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SF_W-1:0]  cfg_data_i,
  input  logic             empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [OUT_W-1:0] m_data_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EMA   = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_MEAN  = 8'b0000_1000,
    S_LRATE = 8'b0001_0000,
    S_MRATE = 8'b0010_0000,
    S_SRATE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  localparam logic [SF_W:0] ONE_Q = {1'b1, {SF_W{1'b0}}};
  localparam int unsigned   EMA_W = SMOOTH_W + 2;

  state_e                     state_q, state_d;
  logic [SF_W-1:0]            a_q, a_d;
  logic [TIME_W-1:0]          last_q, last_d;
  logic [TOTAL_W-1:0]         total_q, total_d;
  logic [SMOOTH_W-1:0]        smooth_q, smooth_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic                       first_q, first_d;
  logic [TIME_W-1:0]          dt_q, dt_d;
  logic [TIME_W+SF_W-1:0]     phi_q, phi_d;
  logic [2*FRAC_W-1:0]        plo_q, plo_d;
  logic [TIME_W+SF_W:0]       pdt_q, pdt_d;
  status_e                    status_q, status_d;
  logic                       running_q, running_d;
  logic [TIME_W-1:0]          mean_q, mean_d;
  logic [RATE_W-1:0]          lrate_q, lrate_d;
  logic [RATE_W-1:0]          mrate_q, mrate_d;
  logic [RATE_W-1:0]          srate_q, srate_d;
  logic                       out_valid_q, out_valid_d;
  logic [OUT_W-1:0]           out_data_q, out_data_d;
  logic [TOTAL_W:0]           tot_sum;
  logic [EMA_W-1:0]           ema_sum;
  logic [SF_W:0]              inv_a;
  logic                       ready_res;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  itss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign m_valid_o   = out_valid_q;
  assign m_data_o    = out_data_q;
  assign tot_sum     = {1'b0, total_q} + (TOTAL_W+1)'(cmd_i.dt);
  assign inv_a       = ONE_Q - {1'b0, a_q};
  assign ema_sum     = EMA_W'(pdt_q) + EMA_W'(phi_q) + EMA_W'(plo_q >> FRAC_W);
  assign ready_res   = !running_q && (count_q != '0);

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    last_d      = last_q;
    total_d     = total_q;
    smooth_d    = smooth_q;
    count_d     = count_q;
    first_d     = first_q;
    dt_d        = dt_q;
    phi_d       = phi_q;
    plo_d       = plo_q;
    pdt_d       = pdt_q;
    status_d    = status_q;
    running_d   = running_q;
    mean_d      = mean_q;
    lrate_d     = lrate_q;
    mrate_d     = mrate_q;
    srate_d     = srate_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    div_req     = '0;

    if (cfg_valid_i) begin
      a_d = cfg_data_i;
    end
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          status_d  = cmd_i.status;
          running_d = cmd_i.running;
          dt_d      = cmd_i.dt;
          state_d   = S_PREP;
          case (cmd_i.act)
            ACT_STOP: begin
              last_d  = cmd_i.dt;
              total_d = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
              if (count_q != '1) begin
                count_d = count_q + COUNT_W'(1);
              end
              first_d = (count_q == '0);
              phi_d   = (TIME_W+SF_W)'(smooth_q[SMOOTH_W-1:FRAC_W]) * (TIME_W+SF_W)'(a_q);
              plo_d   = (2*FRAC_W)'(smooth_q[FRAC_W-1:0]) * (2*FRAC_W)'(a_q);
              pdt_d   = (TIME_W+SF_W+1)'(cmd_i.dt) * (TIME_W+SF_W+1)'(inv_a);
              state_d = S_EMA;
            end
            ACT_CLEAR: begin
              last_d   = '0;
              total_d  = '0;
              smooth_d = '0;
              count_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMA: begin
        smooth_d = first_q ? {dt_q, {FRAC_W{1'b0}}} : ema_sum[SMOOTH_W-1:0];
        state_d  = S_PREP;
      end
      S_PREP: begin
        if (ready_res) begin
          div_req.start = 1'b1;
          div_req.wide  = 1'b1;
          div_req.num   = DIV_NUM_W'(total_q);
          div_req.den   = DIV_DEN_W'(count_q);
          state_d       = S_MEAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MEAN: begin
        if (div_rsp.done) begin
          mean_d        = div_rsp.q;
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(1) << RATE_FRAC;
          div_req.den   = DIV_DEN_W'(last_q);
          state_d       = S_LRATE;
        end
      end
      S_LRATE: begin
        if (div_rsp.done) begin
          lrate_d       = div_rsp.q[RATE_W-1:0];
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(count_q) << RATE_FRAC;
          div_req.den   = DIV_DEN_W'(total_q);
          state_d       = S_MRATE;
        end
      end
      S_MRATE: begin
        if (div_rsp.done) begin
          mrate_d       = div_rsp.q[RATE_W-1:0];
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(1) << (RATE_FRAC + FRAC_W);
          div_req.den   = DIV_DEN_W'(smooth_q);
          state_d       = S_SRATE;
        end
      end
      S_SRATE: begin
        if (div_rsp.done) begin
          srate_d = div_rsp.q[RATE_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          out_valid_d = 1'b1;
          if (ready_res) begin
            out_data_d = OUT_W'({srate_q, mrate_q, lrate_q, smooth_q, mean_q,
                                 last_q, count_q, 1'b1, running_q, status_q});
          end else begin
            out_data_d = OUT_W'({count_q, 1'b0, running_q, status_q});
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= SF_RESET;
      last_q      <= '0;
      total_q     <= '0;
      smooth_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_q         <= a_d;
      last_q      <= last_d;
      total_q     <= total_d;
      smooth_q    <= smooth_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    dt_q       <= dt_d;
    phi_q      <= phi_d;
    plo_q      <= plo_d;
    pdt_q      <= pdt_d;
    status_q   <= status_d;
    running_q  <= running_d;
    mean_q     <= mean_d;
    lrate_q    <= lrate_d;
    mrate_q    <= mrate_d;
    srate_q    <= srate_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q >= TOTAL_W'(count_q))
    else $error("total ticks below interval count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < $past(count_q)) |-> (count_q == '0))
    else $error("interval count decreased without clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q != S_IDLE) && (state_q != S_DONE) && (state_q != S_EMA))
    else $error("division started outside the statistics sequence");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for interval_timer_with_smoothed_stats: directed and random
// start/stop/clear/read traffic, checked against an in-bench timer and statistics predictor.
// Depends on itss_pkg and the RTL under src.

module testbench;
  import itss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned IDLE_PCT       = 36;
  localparam int unsigned REPORT_MAX     = 10;
  localparam logic [63:0] TOTAL_MAX      = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] TIME_MAX       = 64'hFFFF_FFFF;
  localparam logic [63:0] RATE_ONE       = 64'd1 << RATE_FRAC;

  typedef struct packed {
    logic [RATE_W-1:0]   smooth_rate;
    logic [RATE_W-1:0]   mean_rate;
    logic [RATE_W-1:0]   last_rate;
    logic [SMOOTH_W-1:0] smooth_el;
    logic [TIME_W-1:0]   mean_el;
    logic [TIME_W-1:0]   last_el;
    logic [COUNT_W-1:0]  count;
    logic                ready;
    logic                running;
    logic [STATUS_W-1:0] status;
  } stats_t;

  typedef logic [63:0] field_arr_t [10];

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SF_W-1:0]   cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TIME_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]   s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  // predictor state
  logic [SF_W-1:0]     smoothing = SF_RESET;
  logic                timer_running = 1'b0;
  logic [TIME_W-1:0]   start_tick = '0;
  logic [TIME_W-1:0]   last_ticks = '0;
  logic [63:0]         tick_total = '0;
  logic [SMOOTH_W-1:0] ema_ticks = '0;
  logic [COUNT_W-1:0]  interval_cnt = '0;

  stats_t            expected_stats_q [$];
  logic [TIME_W-1:0] tick_now = '0;
  bit                steady_flow = 1'b0;
  int unsigned       failures = 0;
  int unsigned       stall_cycles = 0;
  string             field_name [10] = '{"status", "running", "ready_res", "interval_count",
                                         "last_elapsed", "mean_elapsed", "smooth_elapsed",
                                         "last_rate", "mean_rate", "smooth_rate"};

  interval_timer_with_smoothed_stats DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] capped_quotient(logic [63:0] num, logic [63:0] den,
                                                  logic [63:0] cap);
    logic [63:0] q;
    if (den == 0) return 64'd0;
    q = num / den;
    return (q > cap) ? cap : q;
  endfunction

  function automatic stats_t advance_timer(op_e op, logic [TIME_W-1:0] now);
    stats_t      r;
    logic [31:0] dt32;
    logic [63:0] dt, old_hi, old_lo, a, part, cnt, mrate;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_START: begin
        if (timer_running) begin
          r.status = ST_RUNNING;
        end else begin
          start_tick = now;
          timer_running = 1'b1;
        end
      end
      OP_STOP: begin
        if (!timer_running) begin
          r.status = ST_NOT_STARTED;
        end else begin
          timer_running = 1'b0;
          dt32 = now - start_tick;
          dt = dt32;
          if (dt == 0) dt = 64'd1;
          last_ticks = TIME_W'(dt);
          if (tick_total > TOTAL_MAX - dt) tick_total = TOTAL_MAX;
          else tick_total = tick_total + dt;
          if (interval_cnt != 0) begin
            a = smoothing;
            old_hi = ema_ticks >> FRAC_W;
            old_lo = ema_ticks[FRAC_W-1:0];
            part = old_hi * a + ((old_lo * a) >> FRAC_W);
            ema_ticks = SMOOTH_W'(dt * (64'd65536 - a) + part);
          end else begin
            ema_ticks = SMOOTH_W'(dt << FRAC_W);
          end
          if (interval_cnt != '1) interval_cnt = interval_cnt + 1'b1;
        end
      end
      OP_CLEAR: begin
        timer_running = 1'b0;
        start_tick = now;
        last_ticks = '0;
        tick_total = '0;
        ema_ticks = '0;
        interval_cnt = '0;
      end
      default: ;
    endcase
    r.running = timer_running;
    r.count = interval_cnt;
    if (!timer_running && interval_cnt != 0) begin
      cnt = interval_cnt;
      r.ready = 1'b1;
      r.last_el = last_ticks;
      r.mean_el = TIME_W'(capped_quotient(tick_total, cnt, TIME_MAX));
      r.smooth_el = ema_ticks;
      r.last_rate = RATE_W'(capped_quotient(RATE_ONE, 64'(last_ticks), RATE_ONE));
      if (tick_total == 0) mrate = 64'd0;
      else if (cnt >= tick_total) mrate = RATE_ONE;
      else mrate = capped_quotient(cnt << RATE_FRAC, tick_total, RATE_ONE);
      r.mean_rate = RATE_W'(mrate);
      r.smooth_rate = RATE_W'(capped_quotient(RATE_ONE << FRAC_W, 64'(ema_ticks), RATE_ONE));
    end
    return r;
  endfunction

  function automatic field_arr_t field_values(stats_t r);
    field_arr_t f;
    f[0] = 64'(r.status);
    f[1] = 64'(r.running);
    f[2] = 64'(r.ready);
    f[3] = 64'(r.count);
    f[4] = 64'(r.last_el);
    f[5] = 64'(r.mean_el);
    f[6] = 64'(r.smooth_el);
    f[7] = 64'(r.last_rate);
    f[8] = 64'(r.mean_rate);
    f[9] = 64'(r.smooth_rate);
    return f;
  endfunction

  task automatic log_failure(string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    stats_t     want, got;
    field_arr_t wf, gf;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = stats_t'(m_axis_tdata[$bits(stats_t)-1:0]);
      if (expected_stats_q.size() == 0) begin
        log_failure("result with no request pending");
      end else begin
        want = expected_stats_q.pop_front();
        wf = field_values(want);
        gf = field_values(got);
        for (int i = 0; i < 10; i++) begin
          if (wf[i] !== gf[i])
            log_failure($sformatf("mismatch on %s: expected %0h, got %0h",
                                  field_name[i], wf[i], gf[i]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(op_e op, logic [TIME_W-1:0] stamp);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= stamp;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_stats_q.push_back(advance_timer(op, stamp));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_smoothing(logic [SF_W-1:0] value);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    smoothing = value;
  endtask

  task automatic test_idle_requests();
    send_request(OP_READ, 32'd100);
    send_request(OP_STOP, 32'd200);
    send_request(OP_CLEAR, 32'd300);
    send_request(OP_READ, 32'd400);
  endtask

  task automatic test_start_stop_rules();
    send_request(OP_START, 32'd1000);
    send_request(OP_START, 32'd1500);
    send_request(OP_READ, 32'd1600);
    send_request(OP_STOP, 32'd1000);
    send_request(OP_READ, 32'd1700);
    send_request(OP_STOP, 32'd2000);
  endtask

  task automatic test_interval_extremes();
    send_request(OP_START, 32'hFFFF_FFF0);
    send_request(OP_STOP, 32'h0000_000F);
    send_request(OP_START, 32'h0000_0000);
    send_request(OP_STOP, 32'hFFFF_FFFF);
    send_request(OP_START, 32'h5555_5555);
    send_request(OP_STOP, 32'hAAAA_AAAA);
    send_request(OP_CLEAR, 32'hDEAD_BEEF);
    send_request(OP_READ, 32'h0000_0001);
  endtask

  task automatic test_smoothing_extremes();
    write_smoothing(16'h0000);
    send_request(OP_START, 32'd10);
    send_request(OP_STOP, 32'd20);
    send_request(OP_START, 32'd30);
    send_request(OP_STOP, 32'd70);
    write_smoothing(16'hFFFF);
    send_request(OP_START, 32'd100);
    send_request(OP_STOP, 32'd100_000);
    send_request(OP_READ, 32'd100_001);
    write_smoothing(SF_RESET);
  endtask

  task automatic test_random_traffic(int unsigned n_items, logic [SF_W-1:0] factor);
    int unsigned roll;
    op_e         op;
    write_smoothing(factor);
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) op = timer_running ? OP_STOP : OP_START;
      else if (roll < 85) op = OP_READ;
      else if (roll < 90) op = OP_CLEAR;
      else op = op_e'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 25) tick_now = tick_now + $urandom_range(0, 3);
      else if (roll < 75) tick_now = tick_now + $urandom_range(0, 65535);
      else if (roll < 90) tick_now = $urandom();
      else tick_now = tick_now + 32'hFFFF_FF00 + $urandom_range(0, 255);
      send_request(op, tick_now);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_requests();
    test_start_stop_rules();
    test_interval_extremes();
    test_smoothing_extremes();
    test_random_traffic(250, SF_RESET);
    steady_flow = 1'b1;
    test_random_traffic(250, SF_W'($urandom_range(1, 65534)));
    wait_for_results();
    steady_flow = 1'b0;
    test_random_traffic(250, 16'h0000);
    test_random_traffic(250, 16'hFFFF);
    wait_for_results();
    repeat (150) @(posedge clk_i);
    if (failures == 0 && expected_stats_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
